>>> src/hct_pkg.sv
// shared types, constants and helper functions of the prefix code table block
package hct_pkg;

  // sizing of the tables
  localparam int SYMBOL_BITS  = 8;
  localparam int MAX_CODE_LEN = 16;
  localparam int NODE_COUNT   = 512;

  // fixed port field widths
  localparam int SYM_W      = 8;
  localparam int CODE_W     = 16;
  localparam int LEN_W      = 5;
  localparam int CODE_IDX_W = $clog2(CODE_W);

  // derived widths
  localparam int NODE_AW   = $clog2(NODE_COUNT);
  localparam int USED_W    = NODE_AW + 1;
  localparam int SYM_COUNT = 1 << SYMBOL_BITS;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_ENCODE = 2'd2,
    OP_DECODE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_ACK  = 2'd0,
    KIND_CODE = 2'd1,
    KIND_SYM  = 2'd2,
    KIND_ERR  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_COLLISION = 3'd1,
    STAT_UNKNOWN   = 3'd2,
    STAT_BAD_PATH  = 3'd3,
    STAT_EMPTY     = 3'd4,
    STAT_FULL      = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE       = 4'd0,
    ST_EXEC       = 4'd1,
    ST_INS_STEP   = 4'd2,
    ST_INS_LOAD   = 4'd3,
    ST_INS_FIN    = 4'd4,
    ST_ENC_DATA   = 4'd5,
    ST_DEC_RELOAD = 4'd6,
    ST_DEC_LEAF   = 4'd7,
    ST_RESP       = 4'd8
  } state_t;

  // one tree node as stored in the node memory
  typedef struct packed {
    logic [NODE_AW-1:0]     kid0;
    logic [NODE_AW-1:0]     kid1;
    logic                   leaf;
    logic [SYMBOL_BITS-1:0] sym;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  // one code table entry
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } code_ent_t;

  localparam int CENT_W = $bits(code_ent_t);

  // one result item
  typedef struct packed {
    kind_t             kind;
    logic [SYM_W-1:0]  sym;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    status_t           status;
  } res_t;

  // symbol port value to table index
  function automatic logic [SYMBOL_BITS-1:0] sym_index(input logic [SYM_W-1:0] s);
    logic [SYMBOL_BITS-1:0] r;
    r = '0;
    for (int i = 0; i < SYMBOL_BITS; i++) begin
      if (i < SYM_W) r[i] = s[i];
    end
    return r;
  endfunction

  // table symbol to symbol port value
  function automatic logic [SYM_W-1:0] sym_out(input logic [SYMBOL_BITS-1:0] s);
    logic [SYM_W-1:0] r;
    r = '0;
    for (int i = 0; i < SYM_W; i++) begin
      if (i < SYMBOL_BITS) r[i] = s[i];
    end
    return r;
  endfunction

  // keep only the code bits below the code length
  function automatic logic [CODE_W-1:0] code_mask(input logic [CODE_W-1:0] c,
                                                  input logic [LEN_W-1:0] l);
    logic [CODE_W-1:0] r;
    for (int j = 0; j < CODE_W; j++) begin
      r[j] = c[j] & (j < int'(l));
    end
    return r;
  endfunction

  // result with no payload
  function automatic res_t mk_res(input kind_t k, input status_t s);
    res_t r;
    r.kind   = k;
    r.sym    = '0;
    r.code   = '0;
    r.len    = '0;
    r.status = s;
    return r;
  endfunction

endpackage

>>> src/hct_ram.sv
// generic single write port ram with registered read
module hct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/hct_outq.sv
// result output register between the controller and the result channel
module hct_outq (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      res_valid,
  input  hct_pkg::res_t             res_data,
  output logic                      res_ready,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_kind,
  output logic [hct_pkg::SYM_W-1:0] out_symbol,
  output logic [hct_pkg::CODE_W-1:0] out_code,
  output logic [hct_pkg::LEN_W-1:0] out_length,
  output logic [2:0]                out_status
);
  import hct_pkg::*;

  logic out_valid_r;
  logic out_valid_nxt;
  res_t out_data_r;

  // slot is free when empty or being drained this cycle
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload follows the load condition
  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = out_data_r.kind;
  assign out_symbol = out_data_r.sym;
  assign out_code   = out_data_r.code;
  assign out_length = out_data_r.len;
  assign out_status = out_data_r.status;

endmodule

>>> src/hct_ctrl.sv
// sequencer for clear, insert, encode and decode over the node and code memories
module hct_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  // request channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_operation,
  input  logic [hct_pkg::SYM_W-1:0]      in_symbol,
  input  logic [hct_pkg::CODE_W-1:0]     in_code,
  input  logic [hct_pkg::LEN_W-1:0]      in_code_length,
  input  logic                           in_bit_req,
  input  logic                           in_last,
  // node memory
  output logic                           nd_we,
  output logic [hct_pkg::NODE_AW-1:0]    nd_waddr,
  output hct_pkg::node_t                 nd_wdata,
  output logic                           nd_re,
  output logic [hct_pkg::NODE_AW-1:0]    nd_raddr,
  input  hct_pkg::node_t                 nd_rdata,
  // code memory
  output logic                           cd_we,
  output logic [hct_pkg::SYMBOL_BITS-1:0] cd_waddr,
  output hct_pkg::code_ent_t             cd_wdata,
  output logic                           cd_re,
  output logic [hct_pkg::SYMBOL_BITS-1:0] cd_raddr,
  input  hct_pkg::code_ent_t             cd_rdata,
  // result to output register
  output logic                           res_valid,
  output hct_pkg::res_t                  res_data,
  input  logic                           res_ready
);
  import hct_pkg::*;

  // control state
  state_t                 state_r, state_nxt;
  logic [USED_W-1:0]      nodes_used_r, nodes_used_nxt;
  logic [NODE_AW-1:0]     root_kid0_r, root_kid0_nxt;
  logic [NODE_AW-1:0]     root_kid1_r, root_kid1_nxt;
  logic [SYM_COUNT-1:0]   code_valid_r, code_valid_nxt;
  logic                   any_sym_r, any_sym_nxt;
  logic [NODE_AW-1:0]     dec_node_r, dec_node_nxt;
  logic                   dec_ent_ok_r, dec_ent_ok_nxt;

  // request and walk registers
  op_t                    op_r, op_nxt;
  logic [SYMBOL_BITS-1:0] sym_r, sym_nxt;
  logic [CODE_W-1:0]      code_r, code_nxt;
  logic [LEN_W-1:0]       len_r, len_nxt;
  logic                   bit_r, bit_nxt;
  logic                   last_r, last_nxt;
  logic [NODE_AW-1:0]     node_r, node_nxt;
  node_t                  ent_r, ent_nxt;
  logic [LEN_W-1:0]       idx_r, idx_nxt;
  node_t                  dec_ent_r, dec_ent_nxt;
  res_t                   res_pend_r, res_pend_nxt;

  // combinational helpers
  logic                   do_clear;
  logic                   walk_bit;
  logic                   at_end;
  logic [NODE_AW-1:0]     walk_ch;
  logic [NODE_AW-1:0]     new_node;
  node_t                  upd_ent;
  logic [NODE_AW-1:0]     dec_cur;
  logic [NODE_AW-1:0]     dec_k0;
  logic [NODE_AW-1:0]     dec_k1;
  logic [NODE_AW-1:0]     dec_ch;
  code_ent_t              new_code;

  // insert walk: current bit, end of code, child on that branch
  assign walk_bit = (idx_r < LEN_W'(CODE_W)) ? code_r[idx_r[CODE_IDX_W-1:0]] : 1'b0;
  assign at_end   = ((idx_r + LEN_W'(1)) == len_r);
  assign walk_ch  = walk_bit ? ent_r.kid1 : ent_r.kid0;
  assign new_node = nodes_used_r[NODE_AW-1:0];

  always_comb begin
    upd_ent = ent_r;
    if (walk_bit) begin
      upd_ent.kid1 = new_node;
    end else begin
      upd_ent.kid0 = new_node;
    end
  end

  // decode step: current node links from root flops or cached entry
  assign dec_cur = ({1'b0, dec_node_r} >= nodes_used_r) ? '0 : dec_node_r;
  assign dec_k0  = (dec_cur == '0) ? root_kid0_r : dec_ent_r.kid0;
  assign dec_k1  = (dec_cur == '0) ? root_kid1_r : dec_ent_r.kid1;
  assign dec_ch  = bit_r ? dec_k1 : dec_k0;

  always_comb begin
    new_code.code = code_mask(code_r, len_r);
    new_code.len  = len_r;
  end

  // next state and outputs
  always_comb begin
    state_nxt      = state_r;
    nodes_used_nxt = nodes_used_r;
    root_kid0_nxt  = root_kid0_r;
    root_kid1_nxt  = root_kid1_r;
    code_valid_nxt = code_valid_r;
    any_sym_nxt    = any_sym_r;
    dec_node_nxt   = dec_node_r;
    dec_ent_ok_nxt = dec_ent_ok_r;
    op_nxt         = op_r;
    sym_nxt        = sym_r;
    code_nxt       = code_r;
    len_nxt        = len_r;
    bit_nxt        = bit_r;
    last_nxt       = last_r;
    node_nxt       = node_r;
    ent_nxt        = ent_r;
    idx_nxt        = idx_r;
    dec_ent_nxt    = dec_ent_r;
    res_pend_nxt   = res_pend_r;

    in_ready  = 1'b0;
    nd_we     = 1'b0;
    nd_waddr  = node_r;
    nd_wdata  = ent_r;
    nd_re     = 1'b0;
    nd_raddr  = walk_ch;
    cd_we     = 1'b0;
    cd_waddr  = sym_r;
    cd_wdata  = new_code;
    cd_re     = 1'b0;
    cd_raddr  = sym_r;
    res_valid = 1'b0;
    res_data  = res_pend_r;
    do_clear  = 1'b0;

    case (state_r)
      // take a request
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt    = op_t'(in_operation);
          sym_nxt   = sym_index(in_symbol);
          code_nxt  = in_code;
          len_nxt   = in_code_length;
          bit_nxt   = in_bit_req;
          last_nxt  = in_last;
          state_nxt = ST_EXEC;
        end
      end

      // dispatch on the operation
      ST_EXEC: begin
        case (op_r)
          OP_CLEAR: begin
            do_clear  = 1'b1;
            res_valid = 1'b1;
            res_data  = mk_res(KIND_ACK, STAT_OK);
          end
          OP_INSERT: begin
            dec_ent_ok_nxt = 1'b0;
            if (len_r == '0 || int'(len_r) > MAX_CODE_LEN) begin
              res_valid = 1'b1;
              res_data  = mk_res(KIND_ERR, STAT_BAD_PATH);
            end else if (code_valid_r[sym_r]) begin
              do_clear  = 1'b1;
              res_valid = 1'b1;
              res_data  = mk_res(KIND_ERR, STAT_COLLISION);
            end else begin
              node_nxt      = '0;
              ent_nxt.kid0  = root_kid0_r;
              ent_nxt.kid1  = root_kid1_r;
              ent_nxt.leaf  = 1'b0;
              ent_nxt.sym   = '0;
              idx_nxt       = '0;
              state_nxt     = ST_INS_STEP;
            end
          end
          OP_ENCODE: begin
            if (!any_sym_r) begin
              res_valid = 1'b1;
              res_data  = mk_res(KIND_ERR, STAT_EMPTY);
            end else if (!code_valid_r[sym_r]) begin
              res_valid = 1'b1;
              res_data  = mk_res(KIND_ERR, STAT_UNKNOWN);
            end else begin
              cd_re     = 1'b1;
              state_nxt = ST_ENC_DATA;
            end
          end
          OP_DECODE: begin
            if (!any_sym_r) begin
              dec_node_nxt = '0;
              res_valid    = 1'b1;
              res_data     = mk_res(KIND_ERR, STAT_EMPTY);
            end else if (dec_cur != '0 && !dec_ent_ok_r) begin
              // cached entry is stale after an insert
              dec_node_nxt = dec_cur;
              nd_re        = 1'b1;
              nd_raddr     = dec_cur;
              state_nxt    = ST_DEC_RELOAD;
            end else if (dec_ch == '0 || {1'b0, dec_ch} >= nodes_used_r) begin
              dec_node_nxt = '0;
              res_valid    = 1'b1;
              res_data     = mk_res(KIND_ERR, STAT_BAD_PATH);
            end else begin
              nd_re     = 1'b1;
              nd_raddr  = dec_ch;
              node_nxt  = dec_ch;
              state_nxt = ST_DEC_LEAF;
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end

      // one insert step: allocate a node or follow an existing branch
      ST_INS_STEP: begin
        if (walk_ch == '0) begin
          if (nodes_used_r >= USED_W'(NODE_COUNT)) begin
            do_clear  = 1'b1;
            res_valid = 1'b1;
            res_data  = mk_res(KIND_ERR, STAT_FULL);
          end else begin
            nodes_used_nxt = nodes_used_r + USED_W'(1);
            if (node_r == '0) begin
              root_kid0_nxt = upd_ent.kid0;
              root_kid1_nxt = upd_ent.kid1;
            end else begin
              nd_we    = 1'b1;
              nd_waddr = node_r;
              nd_wdata = upd_ent;
            end
            ent_nxt.kid0 = '0;
            ent_nxt.kid1 = '0;
            ent_nxt.leaf = at_end;
            ent_nxt.sym  = sym_r;
            node_nxt     = new_node;
            idx_nxt      = idx_r + LEN_W'(1);
            state_nxt    = at_end ? ST_INS_FIN : ST_INS_STEP;
          end
        end else if (at_end) begin
          do_clear  = 1'b1;
          res_valid = 1'b1;
          res_data  = mk_res(KIND_ERR, STAT_COLLISION);
        end else begin
          nd_re     = 1'b1;
          nd_raddr  = walk_ch;
          node_nxt  = walk_ch;
          idx_nxt   = idx_r + LEN_W'(1);
          state_nxt = ST_INS_LOAD;
        end
      end

      // existing child arrives: a leaf on the path is a collision
      ST_INS_LOAD: begin
        if (nd_rdata.leaf) begin
          do_clear  = 1'b1;
          res_valid = 1'b1;
          res_data  = mk_res(KIND_ERR, STAT_COLLISION);
        end else begin
          ent_nxt   = nd_rdata;
          state_nxt = ST_INS_STEP;
        end
      end

      // write the new leaf and the code table entry
      ST_INS_FIN: begin
        nd_we                  = 1'b1;
        nd_waddr               = node_r;
        nd_wdata               = ent_r;
        cd_we                  = 1'b1;
        code_valid_nxt[sym_r]  = 1'b1;
        any_sym_nxt            = 1'b1;
        res_valid              = 1'b1;
        res_data               = mk_res(KIND_ACK, STAT_OK);
      end

      // code table read data
      ST_ENC_DATA: begin
        res_valid     = 1'b1;
        res_data      = mk_res(KIND_CODE, STAT_OK);
        res_data.code = cd_rdata.code;
        res_data.len  = cd_rdata.len;
      end

      // refill the decoder's cached node and retry the step
      ST_DEC_RELOAD: begin
        dec_ent_nxt    = nd_rdata;
        dec_ent_ok_nxt = 1'b1;
        state_nxt      = ST_EXEC;
      end

      // child arrives: emit at a leaf, else descend
      ST_DEC_LEAF: begin
        if (nd_rdata.leaf) begin
          dec_node_nxt = '0;
          res_valid    = 1'b1;
          res_data     = mk_res(KIND_SYM, STAT_OK);
          res_data.sym = sym_out(nd_rdata.sym);
        end else begin
          dec_node_nxt   = last_r ? '0 : node_r;
          dec_ent_nxt    = nd_rdata;
          dec_ent_ok_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end

      // result waits for the output register
      ST_RESP: begin
        res_valid = 1'b1;
        res_data  = res_pend_r;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // hand over the result or park it
    if (res_valid) begin
      res_pend_nxt = res_data;
      state_nxt    = res_ready ? ST_IDLE : ST_RESP;
    end

    // empty both tables
    if (do_clear) begin
      nodes_used_nxt = USED_W'(1);
      root_kid0_nxt  = '0;
      root_kid1_nxt  = '0;
      code_valid_nxt = '0;
      any_sym_nxt    = 1'b0;
      dec_node_nxt   = '0;
      dec_ent_ok_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      nodes_used_r <= USED_W'(1);
      root_kid0_r  <= '0;
      root_kid1_r  <= '0;
      code_valid_r <= '0;
      any_sym_r    <= 1'b0;
      dec_node_r   <= '0;
      dec_ent_ok_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      nodes_used_r <= nodes_used_nxt;
      root_kid0_r  <= root_kid0_nxt;
      root_kid1_r  <= root_kid1_nxt;
      code_valid_r <= code_valid_nxt;
      any_sym_r    <= any_sym_nxt;
      dec_node_r   <= dec_node_nxt;
      dec_ent_ok_r <= dec_ent_ok_nxt;
    end
  end

  // request and walk registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    sym_r      <= sym_nxt;
    code_r     <= code_nxt;
    len_r      <= len_nxt;
    bit_r      <= bit_nxt;
    last_r     <= last_nxt;
    node_r     <= node_nxt;
    ent_r      <= ent_nxt;
    idx_r      <= idx_nxt;
    dec_ent_r  <= dec_ent_nxt;
    res_pend_r <= res_pend_nxt;
  end

`ifndef NO_ASSERTIONS
  // the root lives in flops and is never written to the node memory
  a_no_root_write: assert property (@(posedge clk) disable iff (!rst_n)
    nd_we |-> nd_waddr != '0)
    else $error("node memory write to root");

  // no symbol held means no valid code table entry
  a_valid_vs_any: assert property (@(posedge clk) disable iff (!rst_n)
    !any_sym_r |-> code_valid_r == '0)
    else $error("code valid bit set with empty table");

  // decoder position always points at an allocated node
  a_dec_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, dec_node_r} < nodes_used_r)
    else $error("decoder node beyond allocated nodes");

  // an accepted request is dispatched in the next cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_EXEC)
    else $error("accepted request not dispatched");
`endif

endmodule

>>> src/huffman_table_coder_top.sv
// prefix code table block: code memory, node memory, sequencer and output register
// insert walks the code's path, allocating a node for each new branch and reading each existing node
// a mid-code decode bit right after an insert first reloads the cached node
// one request is in flight at a time; the next request is taken while a result waits in the output register
// reset clears control state, root links and code valid bits at once; no clearing pass
module huffman_table_coder_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_operation,
  input  logic [hct_pkg::SYM_W-1:0]   in_symbol,
  input  logic [hct_pkg::CODE_W-1:0]  in_code,
  input  logic [hct_pkg::LEN_W-1:0]   in_code_length,
  input  logic                        in_bit_req,
  input  logic                        in_last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_kind,
  output logic [hct_pkg::SYM_W-1:0]   out_symbol,
  output logic [hct_pkg::CODE_W-1:0]  out_code,
  output logic [hct_pkg::LEN_W-1:0]   out_length,
  output logic [2:0]                  out_status
);
  import hct_pkg::*;

  logic                   nd_we;
  logic [NODE_AW-1:0]     nd_waddr;
  node_t                  nd_wdata;
  logic                   nd_re;
  logic [NODE_AW-1:0]     nd_raddr;
  node_t                  nd_rdata;
  logic                   cd_we;
  logic [SYMBOL_BITS-1:0] cd_waddr;
  code_ent_t              cd_wdata;
  logic                   cd_re;
  logic [SYMBOL_BITS-1:0] cd_raddr;
  code_ent_t              cd_rdata;
  logic                   res_valid;
  res_t                   res_data;
  logic                   res_ready;

  // sequencer
  hct_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_symbol      (in_symbol),
    .in_code        (in_code),
    .in_code_length (in_code_length),
    .in_bit_req     (in_bit_req),
    .in_last        (in_last),
    .nd_we          (nd_we),
    .nd_waddr       (nd_waddr),
    .nd_wdata       (nd_wdata),
    .nd_re          (nd_re),
    .nd_raddr       (nd_raddr),
    .nd_rdata       (nd_rdata),
    .cd_we          (cd_we),
    .cd_waddr       (cd_waddr),
    .cd_wdata       (cd_wdata),
    .cd_re          (cd_re),
    .cd_raddr       (cd_raddr),
    .cd_rdata       (cd_rdata),
    .res_valid      (res_valid),
    .res_data       (res_data),
    .res_ready      (res_ready)
  );

  // decoding tree nodes
  hct_ram #(
    .WIDTH (NODE_W),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk   (clk),
    .we    (nd_we),
    .waddr (nd_waddr),
    .wdata (nd_wdata),
    .re    (nd_re),
    .raddr (nd_raddr),
    .rdata (nd_rdata)
  );

  // code and length per symbol
  hct_ram #(
    .WIDTH (CENT_W),
    .DEPTH (SYM_COUNT)
  ) u_code_ram (
    .clk   (clk),
    .we    (cd_we),
    .waddr (cd_waddr),
    .wdata (cd_wdata),
    .re    (cd_re),
    .raddr (cd_raddr),
    .rdata (cd_rdata)
  );

  // result register
  hct_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res_data   (res_data),
    .res_ready  (res_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_kind   (out_kind),
    .out_symbol (out_symbol),
    .out_code   (out_code),
    .out_length (out_length),
    .out_status (out_status)
  );

endmodule
